[design/mctt_pkg.sv]
// shared types and constants for the multi-channel tick timer unit
`timescale 1ns / 1ps
`default_nettype none

package mctt_pkg;

   localparam int NUM_TIMERS  = 3;
   localparam int TIMER_W     = 3;
   localparam int MS_W        = 16;
   localparam int CNT_W       = 32;
   localparam int MASK_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 8;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2,
      REQ_INIT  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      RK_EXPIRED   = 3'd0,
      RK_STARTED   = 3'd1,
      RK_STOPPED   = 3'd2,
      RK_BAD_ID    = 3'd3,
      RK_INIT      = 3'd4,
      RK_TICK_DONE = 3'd5
   } result_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REPEAT_MASK    = 2'd0,
      CSR_AUTOSTART_MASK = 2'd1,
      CSR_INIT_PERIOD    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      RUN_STOPPED  = 2'd0,
      RUN_RUNNING  = 2'd1,
      RUN_TIMEDOUT = 2'd2
   } run_state_type;

   // broadcast to every cell
   typedef struct packed {
      logic             shift;
      logic             step;
      logic             start;
      logic             stop;
      logic             init;
      logic [MS_W-1:0]  elapsed_ms;
      logic [CNT_W-1:0] period_ms;
      logic [CNT_W-1:0] init_period;
   } cell_cmd_type;

   // expiry flag rippling down the chain
   typedef struct packed {
      logic               expired;
      logic [TIMER_W-1:0] timer;
   } hit_type;

endpackage

`default_nettype wire

[design/multi_channel_tick_timer_unit.sv]
// top level: request decode, configuration registers, chain of timer cells, result register
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  user            data                                          last
// req_     in         req_type[1:0]   timer_id[2:0] elapsed_ms[18:3] period_ms[50:19]  -
// rsp_     out        result_kind     result_timer[2:0]                              is_last
// csr_     in         -               index 0 repeat, 1 autostart, 2 init period     -
//
// start, stop, init and bad id each give one result
// a tick sends the visit token down the chain of cells, one cell per cycle
// the token only moves while the result register is free, so a stall holds it
// reset clears all timers to stopped, configuration to its defaults

module multi_channel_tick_timer_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [mctt_pkg::REQ_DATA_W-1:0]   req_tdata,   // timer_id, elapsed_ms, period_ms
   input  wire [1:0]                        req_tuser,   // req_type
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [mctt_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // result_timer
   output logic [2:0]                       rsp_tuser,   // result_kind
   output logic                             rsp_tlast,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [mctt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [mctt_pkg::CSR_DATA_W-1:0]   csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TICK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [mctt_pkg::MASK_W-1:0]       repeat_ff, repeat_in;
   logic [mctt_pkg::MASK_W-1:0]       auto_ff, auto_in;
   logic [mctt_pkg::CNT_W-1:0]        iper_ff, iper_in;
   logic [mctt_pkg::MS_W-1:0]         ms_ff, ms_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   mctt_pkg::result_kind_type         rsp_kind_ff, rsp_kind_in;
   logic [mctt_pkg::TIMER_W-1:0]      rsp_timer_ff, rsp_timer_in;
   logic                              rsp_last_ff, rsp_last_in;

   mctt_pkg::req_code_type            req_code;
   logic [mctt_pkg::TIMER_W-1:0]      req_id;
   logic [mctt_pkg::MS_W-1:0]         req_ms;
   logic [mctt_pkg::CNT_W-1:0]        req_period;
   logic                              out_free;
   logic                              req_acc;
   logic                              bad_id;
   logic                              step;
   mctt_pkg::cell_cmd_type            cmd;

   logic    [mctt_pkg::NUM_TIMERS:0]  tok_chain;
   mctt_pkg::hit_type                 hit_chain [mctt_pkg::NUM_TIMERS+1];

   assign req_code   = mctt_pkg::req_code_type'(req_tuser);
   assign req_id     = req_tdata[2:0];
   assign req_ms     = req_tdata[18:3];
   assign req_period = req_tdata[50:19];

   assign out_free   = !rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) & out_free;
   assign req_acc    = req_tvalid & req_tready;
   assign bad_id     = {1'b0, req_id} >= (mctt_pkg::TIMER_W + 1)'(mctt_pkg::NUM_TIMERS);
   assign step       = (state_ff == ST_TICK) & out_free;
   assign csr_ready  = 1'b1;

   always_comb begin
      cmd.shift       = step | (req_acc & (req_code == mctt_pkg::REQ_TICK));
      cmd.step        = step;
      cmd.start       = req_acc & (req_code == mctt_pkg::REQ_START) & !bad_id;
      cmd.stop        = req_acc & (req_code == mctt_pkg::REQ_STOP) & !bad_id;
      cmd.init        = req_acc & (req_code == mctt_pkg::REQ_INIT);
      cmd.elapsed_ms  = ms_ff;
      cmd.period_ms   = req_period;
      cmd.init_period = iper_ff;
   end

   // token enters cell 0 on a tick transfer
   assign tok_chain[0]         = req_acc & (req_code == mctt_pkg::REQ_TICK);
   assign hit_chain[0].expired = 1'b0;
   assign hit_chain[0].timer   = '0;

   for (genvar i = 0; i < mctt_pkg::NUM_TIMERS; i++) begin : g_cell
      mctt_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .sel           (req_id == mctt_pkg::TIMER_W'(i)),
         .repeat_bit    (repeat_ff[i]),
         .autostart_bit (auto_ff[i]),
         .cell_id       (mctt_pkg::TIMER_W'(i)),
         .tok_in        (tok_chain[i]),
         .tok_out       (tok_chain[i+1]),
         .hit_in        (hit_chain[i]),
         .hit_out       (hit_chain[i+1])
      );
   end

   always_comb begin
      repeat_in = repeat_ff;
      auto_in   = auto_ff;
      iper_in   = iper_ff;
      if (csr_valid & csr_ready) begin
         unique case (csr_index)
            mctt_pkg::CSR_REPEAT_MASK:    repeat_in = csr_data[mctt_pkg::MASK_W-1:0];
            mctt_pkg::CSR_AUTOSTART_MASK: auto_in   = csr_data[mctt_pkg::MASK_W-1:0];
            mctt_pkg::CSR_INIT_PERIOD:    iper_in   = csr_data;
            default:                      ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      ms_in        = ms_ff;
      rsp_valid_in = rsp_valid_ff & !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_timer_in = rsp_timer_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_code == mctt_pkg::REQ_TICK) begin
                  ms_in    = req_ms;
                  state_in = ST_TICK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_timer_in = req_id;
                  if (req_code == mctt_pkg::REQ_INIT) begin
                     rsp_kind_in  = mctt_pkg::RK_INIT;
                     rsp_timer_in = '0;
                  end else if (bad_id) begin
                     rsp_kind_in = mctt_pkg::RK_BAD_ID;
                  end else if (req_code == mctt_pkg::REQ_START) begin
                     rsp_kind_in = mctt_pkg::RK_STARTED;
                  end else begin
                     rsp_kind_in = mctt_pkg::RK_STOPPED;
                  end
               end
            end
         end
         ST_TICK: begin
            if (step) begin
               if (hit_chain[mctt_pkg::NUM_TIMERS].expired) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = mctt_pkg::RK_EXPIRED;
                  rsp_timer_in = hit_chain[mctt_pkg::NUM_TIMERS].timer;
                  rsp_last_in  = 1'b0;
               end
               if (tok_chain[mctt_pkg::NUM_TIMERS]) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = mctt_pkg::RK_TICK_DONE;
               rsp_timer_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         repeat_ff    <= mctt_pkg::MASK_W'(4);
         auto_ff      <= mctt_pkg::MASK_W'(4);
         iper_ff      <= mctt_pkg::CNT_W'(15);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         repeat_ff    <= repeat_in;
         auto_ff      <= auto_in;
         iper_ff      <= iper_in;
      end
   end

   always_ff @(posedge clock) begin
      ms_ff        <= ms_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_timer_ff <= rsp_timer_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(mctt_pkg::RSP_DATA_W - mctt_pkg::TIMER_W){1'b0}}, rsp_timer_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[design/mctt_cell.sv]
// one timer cell: run state, count and period, with a visit token passed to the next cell
`timescale 1ns / 1ps
`default_nettype none

module mctt_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  mctt_pkg::cell_cmd_type       cmd,
   input  wire                          sel,
   input  wire                          repeat_bit,
   input  wire                          autostart_bit,
   input  wire [mctt_pkg::TIMER_W-1:0]  cell_id,
   input  wire                          tok_in,
   output logic                         tok_out,
   input  mctt_pkg::hit_type            hit_in,
   output mctt_pkg::hit_type            hit_out
);

   mctt_pkg::run_state_type          run_ff, run_in;
   logic [mctt_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [mctt_pkg::CNT_W-1:0]       per_ff, per_in;
   logic                             tok_ff, tok_in_next;
   logic [mctt_pkg::CNT_W:0]         sum;
   logic [mctt_pkg::CNT_W-1:0]       sat;
   logic                             visit;
   logic                             expire;

   assign visit = tok_ff & cmd.step & (run_ff == mctt_pkg::RUN_RUNNING);

   always_comb begin
      sum    = {1'b0, cnt_ff} + {{(mctt_pkg::CNT_W + 1 - mctt_pkg::MS_W){1'b0}}, cmd.elapsed_ms};
      sat    = sum[mctt_pkg::CNT_W] ? {mctt_pkg::CNT_W{1'b1}} : sum[mctt_pkg::CNT_W-1:0];
      expire = visit & (sat >= per_ff);
   end

   always_comb begin
      run_in      = run_ff;
      cnt_in      = cnt_ff;
      per_in      = per_ff;
      tok_in_next = cmd.shift ? tok_in : tok_ff;
      if (cmd.init) begin
         per_in = cmd.init_period;
         cnt_in = '0;
         run_in = autostart_bit ? mctt_pkg::RUN_RUNNING : mctt_pkg::RUN_STOPPED;
      end else if (cmd.start & sel) begin
         per_in = cmd.period_ms;
         cnt_in = '0;
         run_in = mctt_pkg::RUN_RUNNING;
      end else if (cmd.stop & sel) begin
         if (run_ff != mctt_pkg::RUN_TIMEDOUT) begin
            run_in = mctt_pkg::RUN_STOPPED;
         end
      end else if (visit) begin
         if (expire) begin
            cnt_in = '0;
            if (!repeat_bit) begin
               run_in = mctt_pkg::RUN_TIMEDOUT;
            end
         end else begin
            cnt_in = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= mctt_pkg::RUN_STOPPED;
         cnt_ff <= '0;
         per_ff <= '0;
         tok_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         per_ff <= per_in;
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out         = tok_ff;
   assign hit_out.expired = hit_in.expired | expire;
   assign hit_out.timer   = expire ? cell_id : hit_in.timer;

endmodule

`default_nettype wire
